@@ src/gdes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gdes_pkg;

  localparam int FIELD_BITS      = 16;
  localparam int CFG_BITS        = 17;
  localparam int CFG_IDX_BITS    = 1;
  localparam int PIXEL_BITS_DEF  = 16;
  localparam int EXP_ENTRIES_DEF = 256;
  localparam int WT_BITS         = 17;
  localparam int WSUM_BITS       = 19;
  localparam int TAPS            = 9;
  localparam int CENTRE_TAP      = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_STRENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIGMA    = 1'b1;

  localparam logic [CFG_BITS-1:0] STRENGTH_RESET = 17'd0;
  localparam logic [CFG_BITS-1:0] SIGMA_RESET    = 17'd7864;

  localparam logic [15:0]         W_SIDE   = 16'd46341;
  localparam logic [WT_BITS-1:0]  W_CENTRE = 17'd65536;

  typedef struct packed {
    logic [FIELD_BITS-1:0] depth_above;
    logic [FIELD_BITS-1:0] depth_mid;
    logic [FIELD_BITS-1:0] depth_below;
    logic [FIELD_BITS-1:0] luma_above;
    logic [FIELD_BITS-1:0] luma_mid;
    logic [FIELD_BITS-1:0] luma_below;
    logic                  row_start;
    logic                  row_finish;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] depth_out;
    logic                  row_end;
    logic                  run_last;
  } out_item_t;

  typedef struct packed {
    logic row_end;
    logic run_last;
  } flags_t;

  function automatic logic [63:0] div_small(input logic [63:0] x, input int k);
    logic [63:0] r;
    case (k)
      1:       r = x;
      2:       r = x / 64'd2;
      3:       r = x / 64'd3;
      4:       r = x / 64'd4;
      5:       r = x / 64'd5;
      6:       r = x / 64'd6;
      7:       r = x / 64'd7;
      8:       r = x / 64'd8;
      9:       r = x / 64'd9;
      10:      r = x / 64'd10;
      11:      r = x / 64'd11;
      12:      r = x / 64'd12;
      13:      r = x / 64'd13;
      default: r = x;
    endcase
    return r;
  endfunction

  // exp(-t) with t16 = t in Q16: Taylor series of exp(-t/16) in Q2.30, squared four times.
  function automatic logic [WT_BITS-1:0] exp_entry(input logic [63:0] t16);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    y    = t16 << 10;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 13; k++) begin
      term = div_small((term * y) >> 30, k);
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int s = 0; s < 4; s++) sum = (sum * sum) >> 30;
    return WT_BITS'((sum + 64'd8192) >> 14);
  endfunction

endpackage
`default_nettype wire

@@ src/gdes_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface gdes_in_if;
  import gdes_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gdes_out_if;
  import gdes_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/gdes_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gdes_filter #(
  parameter int PIXEL_BITS        = gdes_pkg::PIXEL_BITS_DEF,
  parameter int EXP_TABLE_ENTRIES = gdes_pkg::EXP_ENTRIES_DEF,
  parameter int RECIP_BITS        = PIXEL_BITS + $clog2(EXP_TABLE_ENTRIES + 8) + 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          job_valid,
  input  wire logic [PIXEL_BITS-1:0]         job_depth [gdes_pkg::TAPS],
  input  wire logic [PIXEL_BITS-1:0]         job_luma  [gdes_pkg::TAPS],
  input  wire gdes_pkg::flags_t              job_flags,
  input  wire logic [RECIP_BITS-1:0]         recip,
  input  wire logic [PIXEL_BITS:0]           sigma_c,
  input  wire logic [gdes_pkg::CFG_BITS-1:0] strength,
  output logic                               out_valid,
  output logic [PIXEL_BITS-1:0]              out_depth,
  output gdes_pkg::flags_t                   out_flags
);
  import gdes_pkg::*;

  localparam int P    = PIXEL_BITS;
  localparam int E    = EXP_TABLE_ENTRIES;
  localparam int CW   = $clog2(E + 8);
  localparam int NW   = P + CW;
  localparam int K    = 2 * P + 4 + CW;
  localparam int PW   = NW + RECIP_BITS;
  localparam int XW   = PW - K;
  localparam int IW   = $clog2(E);
  localparam int DSW  = P + WSUM_BITS;
  localparam int SW   = (CFG_BITS > P + 1) ? CFG_BITS : P + 1;
  localparam int FW   = 2 * P + 2;
  localparam int NST  = P + 10;
  localparam int DIV0 = 8;
  localparam int MULS = P + 8;
  localparam int OUTS = P + 9;
  localparam int unsigned PIX_ONE = 1 << P;
  localparam int unsigned STR_MIN = PIX_ONE / 10000;

  typedef struct packed {
    logic [P-1:0] centre;
    flags_t       flags;
  } side_t;

  logic [NST-1:0] vld;
  side_t          side [NST];

  logic [WT_BITS-1:0] exp_lut [E];
  for (genvar g = 0; g < E; g++) begin : g_lut
    localparam logic [63:0] T16 = (64'(g) * 64'd1048576) / EXP_TABLE_ENTRIES;
    assign exp_lut[g] = exp_entry(T16);
  end

  // Valid bits and the centre pixel with its flags travel down every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{centre: job_depth[CENTRE_TAP], flags: job_flags};
      for (int i = 1; i < NST; i++) side[i] <= side[i-1];
    end
  end

  logic [P-1:0]       d1 [TAPS];
  logic [P-1:0]       l1 [TAPS];
  logic [P-1:0]       d2 [TAPS];
  logic [P-1:0]       d3 [TAPS];
  logic [P-1:0]       d4 [TAPS];
  logic [P-1:0]       d5 [TAPS];
  logic [NW-1:0]      n2 [TAPS-1];
  logic [PW-1:0]      p3 [TAPS-1];
  logic [WT_BITS-1:0] rw4 [TAPS-1];
  logic [WT_BITS-1:0] w5 [TAPS];
  logic [WT_BITS-1:0] w6 [TAPS];
  logic [WT_BITS+P-1:0] wd6 [TAPS];
  logic [WSUM_BITS-1:0] sw7 [3];
  logic [DSW-1:0]       sd7 [3];
  logic [DSW-1:0]       num8;
  logic [WSUM_BITS-1:0] den8;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1 <= job_depth;
      l1 <= job_luma;
      d2 <= d1;
      d3 <= d2;
      d4 <= d3;
      d5 <= d4;
    end
  end

  // Range weight per neighbor: table index = round(|dl| * E / (16 sigma)),
  // taken as (dl*E + 8 sigma) times a reciprocal of 16 sigma.
  for (genvar j = 0; j < TAPS - 1; j++) begin : g_nb
    localparam int T = (j < CENTRE_TAP) ? j : j + 1;
    logic [P-1:0]  dl;
    logic [XW-1:0] idx;
    assign dl  = (l1[CENTRE_TAP] > l1[T]) ? l1[CENTRE_TAP] - l1[T] : l1[T] - l1[CENTRE_TAP];
    assign idx = p3[j][K +: XW];
    always_ff @(posedge clk) begin
      if (adv) begin
        n2[j]  <= NW'(dl) * NW'(E) + NW'({sigma_c, 3'b000});
        p3[j]  <= PW'(n2[j]) * PW'(recip);
        rw4[j] <= (idx < XW'(E)) ? exp_lut[idx[IW-1:0]] : '0;
        w5[T]  <= WT_BITS'((33'(W_SIDE) * 33'(rw4[j]) + 33'd32768) >> 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w5[CENTRE_TAP] <= W_CENTRE;
      for (int t = 0; t < TAPS; t++) begin
        wd6[t] <= (WT_BITS + P)'(w5[t]) * (WT_BITS + P)'(d5[t]);
        w6[t]  <= w5[t];
      end
      for (int g = 0; g < 3; g++) begin
        sw7[g] <= WSUM_BITS'(w6[3*g]) + WSUM_BITS'(w6[3*g+1]) + WSUM_BITS'(w6[3*g+2]);
        sd7[g] <= DSW'(wd6[3*g]) + DSW'(wd6[3*g+1]) + DSW'(wd6[3*g+2]);
      end
      den8 <= sw7[0] + sw7[1] + sw7[2];
      num8 <= sd7[0] + sd7[1] + sd7[2]
              + DSW'((sw7[0] + sw7[1] + sw7[2]) >> 1);
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [WSUM_BITS-1:0] dv_rem [P];
  logic [WSUM_BITS-1:0] dv_den [P];
  logic [P-1:0]         dv_lo  [P];
  logic [P-1:0]         dv_q   [P];

  for (genvar j = 0; j < P; j++) begin : g_div
    logic [WSUM_BITS-1:0] rem_in;
    logic [WSUM_BITS-1:0] den_in;
    logic [P-1:0]         lo_in;
    logic [P-1:0]         q_in;
    logic [WSUM_BITS:0]   tr;
    logic                 ge;
    if (j == 0) begin : g_first
      assign rem_in = num8[DSW-1:P];
      assign den_in = den8;
      assign lo_in  = num8[P-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = dv_rem[j-1];
      assign den_in = dv_den[j-1];
      assign lo_in  = dv_lo[j-1];
      assign q_in   = dv_q[j-1];
    end
    assign tr = {rem_in, lo_in[P-1-j]};
    assign ge = tr >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j] <= ge ? WSUM_BITS'(tr - {1'b0, den_in}) : WSUM_BITS'(tr);
        dv_den[j] <= den_in;
        dv_lo[j]  <= lo_in;
        dv_q[j]   <= q_in | (P'(ge) << (P - 1 - j));
      end
    end
  end

  logic [P-1:0]   blur;
  logic [P-1:0]   ctr_m;
  logic [P:0]     str_c;
  logic [2*P:0]   m_prod;
  logic           m_neg;

  assign blur  = dv_q[P-1];
  assign ctr_m = side[MULS-1].centre;
  assign str_c = (SW'(strength) > SW'(PIX_ONE)) ? (P+1)'(PIX_ONE) : (P+1)'(strength);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_neg  <= ctr_m < blur;
      m_prod <= (2*P+1)'(str_c) * (2*P+1)'((ctr_m >= blur) ? ctr_m - blur : blur - ctr_m);
    end
  end

  logic [P-1:0]  ctr_f;
  logic [FW-1:0] c_q;
  logic [FW-1:0] t_up;
  logic [FW-1:0] t_dn;
  logic [P-1:0]  res;

  assign ctr_f = side[OUTS-1].centre;
  assign c_q   = FW'(ctr_f) << P;
  assign t_up  = c_q + FW'(m_prod) + FW'(PIX_ONE >> 1);
  assign t_dn  = c_q - FW'(m_prod) + FW'(PIX_ONE >> 1);

  always_comb begin
    if (SW'(strength) <= SW'(STR_MIN)) begin
      res = ctr_f;
    end else if (!m_neg) begin
      res = (t_up[FW-1:2*P] != '0) ? '1 : t_up[2*P-1:P];
    end else if (FW'(m_prod) >= c_q) begin
      res = '0;
    end else begin
      res = t_dn[2*P-1:P];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_depth <= res;
  end

  assign out_valid = vld[OUTS];
  assign out_flags = side[OUTS].flags;

endmodule
`default_nettype wire

@@ src/guided_depth_edge_sharpen.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one column per cycle while the pipeline advances (output register free or
// result.ready) and no sigma reciprocal is being formed; a column that ends a row and
// also completes the previous pixel sends a second pixel while column.ready is low, since
// the filter pipeline starts one pixel per advancing cycle.
// Reset: synchronous; clears row state and valid bits and loads register defaults. Then,
// as after each sigma write, column.ready stays low while the sigma reciprocal is formed.
module guided_depth_edge_sharpen #(
  parameter int PIXEL_BITS        = gdes_pkg::PIXEL_BITS_DEF,
  parameter int EXP_TABLE_ENTRIES = gdes_pkg::EXP_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  gdes_in_if.sink                                column,
  gdes_out_if.source                             result,
  input  wire logic                              cfg_write,
  input  wire logic [gdes_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [gdes_pkg::CFG_BITS-1:0]     cfg_data
);
  import gdes_pkg::*;

  localparam int P    = PIXEL_BITS;
  localparam int E    = EXP_TABLE_ENTRIES;
  localparam int CW   = $clog2(E + 8);
  localparam int K    = 2 * P + 4 + CW;
  localparam int RW   = P + CW + 7;
  localparam int DW   = P + 5;
  localparam int NUMW = K + 1;
  localparam int CNTW = $clog2(K + 1);
  localparam int SW   = (CFG_BITS > P + 1) ? CFG_BITS : P + 1;
  localparam int unsigned PIX_ONE = 1 << P;
  localparam int unsigned SIG_MIN = (PIX_ONE + 50) / 100;

  typedef enum logic [2:0] {
    RC_LOAD = 3'b001,
    RC_RUN  = 3'b010,
    RC_DONE = 3'b100
  } rc_state_t;

  // Configuration registers.
  logic [CFG_BITS-1:0] strength;
  logic [CFG_BITS-1:0] sigma;
  logic [P:0]          sigma_c;

  // The sigma used by the filter is held within [0.01, 1.0].
  always_comb begin
    if (SW'(sigma) > SW'(PIX_ONE)) sigma_c = (P+1)'(PIX_ONE);
    else if (SW'(sigma) < SW'(SIG_MIN)) sigma_c = (P+1)'(SIG_MIN);
    else sigma_c = (P+1)'(sigma);
  end

  // The table index needs round(dl*E / (16 sigma)). The divisor only changes on
  // a register write, so a bit-serial divider forms ceil(2^K / (16 sigma)) once,
  // and the pipeline multiplies by it. K is chosen so the product is exact.
  rc_state_t         rc_state;
  logic [NUMW-1:0]   rnum;
  logic [DW-1:0]     rrem;
  logic [RW-1:0]     recip;
  logic [CNTW-1:0]   rcnt;
  logic [DW-1:0]     dsig;
  logic [DW:0]       rtry;
  logic              rge;

  assign dsig = {sigma_c, 4'b0000};
  assign rtry = {rrem, rnum[NUMW-1]};
  assign rge  = rtry >= {1'b0, dsig};

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= STRENGTH_RESET;
      sigma    <= SIGMA_RESET;
      rc_state <= RC_LOAD;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STRENGTH: strength <= cfg_data;
          REG_SIGMA: begin
            sigma    <= cfg_data;
            rc_state <= RC_LOAD;
          end
          default: ;
        endcase
      end
      if (!(cfg_write && cfg_index == REG_SIGMA)) begin
        case (rc_state)
          RC_LOAD: rc_state <= RC_RUN;
          RC_RUN: begin
            if (rcnt == CNTW'(K)) rc_state <= RC_DONE;
          end
          RC_DONE: ;
          default: rc_state <= RC_LOAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (rc_state)
      RC_LOAD: begin
        rnum <= (NUMW'(1) << K) + NUMW'(dsig) - NUMW'(1);
        rrem <= '0;
        rcnt <= '0;
      end
      RC_RUN: begin
        rrem  <= rge ? DW'(rtry - {1'b0, dsig}) : DW'(rtry);
        recip <= {recip[RW-2:0], rge};
        rnum  <= rnum << 1;
        rcnt  <= rcnt + CNTW'(1);
      end
      default: ;
    endcase
  end

  // Window: entries 0..2 are the left column, 3..5 the pending centre column.
  // A row's first pixel sees its own column on the left, and the last pixel
  // sees the centre column again on the right.
  logic [P-1:0] win_d [6];
  logic [P-1:0] win_l [6];
  logic [1:0]   held;
  logic         pend;
  logic [P-1:0] nd [3];
  logic [P-1:0] nl [3];

  assign nd[0] = P'(column.data.depth_above);
  assign nd[1] = P'(column.data.depth_mid);
  assign nd[2] = P'(column.data.depth_below);
  assign nl[0] = P'(column.data.luma_above);
  assign nl[1] = P'(column.data.luma_mid);
  assign nl[2] = P'(column.data.luma_below);

  logic adv;
  logic busy;
  logic accept;
  logic has_prev;
  logic finish;
  logic job_valid;
  logic [P-1:0] job_depth [TAPS];
  logic [P-1:0] job_luma  [TAPS];
  flags_t       job_flags;

  logic         out_valid;
  logic [P-1:0] out_depth;
  flags_t       out_flags;

  // The whole pipeline advances together whenever the output register is empty or result.ready is high.
  assign adv          = !out_valid || result.ready;
  assign busy         = rc_state != RC_DONE;
  assign column.ready = adv && !pend && !busy;
  assign accept       = column.valid && column.ready;
  assign finish       = column.data.row_finish;
  // A row start drops anything held; a column with no open row opens one.
  assign has_prev     = !column.data.row_start && (held != 2'd0);

  // A request finishing a row after a held column needs a second pixel. That
  // one goes from the updated window once the pipeline advances, while column.ready is low.
  assign job_valid = (accept && (has_prev || finish)) || (pend && adv);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      job_depth[r]   = win_d[r];
      job_luma[r]    = win_l[r];
      job_depth[3+r] = win_d[3+r];
      job_luma[3+r]  = win_l[3+r];
      job_depth[6+r] = win_d[3+r];
      job_luma[6+r]  = win_l[3+r];
    end
    job_flags = '{row_end: 1'b1, run_last: 1'b1};
    if (!pend) begin
      if (has_prev) begin
        for (int r = 0; r < 3; r++) begin
          job_depth[6+r] = nd[r];
          job_luma[6+r]  = nl[r];
        end
        job_flags = '{row_end: 1'b0, run_last: !finish};
      end else begin
        for (int r = 0; r < 3; r++) begin
          job_depth[r]   = nd[r];
          job_luma[r]    = nl[r];
          job_depth[3+r] = nd[r];
          job_luma[3+r]  = nl[r];
          job_depth[6+r] = nd[r];
          job_luma[6+r]  = nl[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
      pend <= 1'b0;
    end else if (accept) begin
      if (finish) held <= 2'd0;
      else if (has_prev) held <= 2'd2;
      else held <= 2'd1;
      pend <= finish && has_prev;
    end else if (adv) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r]   <= has_prev ? win_d[3+r] : nd[r];
        win_l[r]   <= has_prev ? win_l[3+r] : nl[r];
        win_d[3+r] <= nd[r];
        win_l[3+r] <= nl[r];
      end
    end
  end

  gdes_filter #(
    .PIXEL_BITS       (PIXEL_BITS),
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES),
    .RECIP_BITS       (RW)
  ) u_filter (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .job_valid(job_valid),
    .job_depth(job_depth),
    .job_luma (job_luma),
    .job_flags(job_flags),
    .recip    (recip),
    .sigma_c  (sigma_c),
    .strength (strength),
    .out_valid(out_valid),
    .out_depth(out_depth),
    .out_flags(out_flags)
  );

  assign result.valid          = out_valid;
  assign result.data.depth_out = FIELD_BITS'(out_depth);
  assign result.data.row_end   = out_flags.row_end;
  assign result.data.run_last  = out_flags.run_last;

endmodule
`default_nettype wire
